// ----- rtl/tablet_protocol5_stream_decoder_assert.svh -----
// Assertion helpers for the tablet stream decoder.
// Each use expects clk and rst in scope.
`ifndef TABLET_PROTOCOL5_STREAM_DECODER_ASSERT_SVH
`define TABLET_PROTOCOL5_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define TP5_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tp5 assertion failed");

// next-cycle implication
`define TP5_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tp5 assertion failed");

`endif

// ----- rtl/tp5_pkg.sv -----
package tp5_pkg;

  localparam int FRAME_LENGTH = 9;

  typedef logic [7:0] oct_t;
  typedef oct_t [FRAME_LENGTH-1:0] frame_t;

  typedef enum logic [2:0] {
    KIND_TOOL_ID  = 3'd0,
    KIND_OUT_PROX = 3'd1,
    KIND_PEN      = 3'd2,
    KIND_AIRBRUSH = 3'd3,
    KIND_MOUSE4D  = 3'd4,
    KIND_LENS     = 3'd5,
    KIND_MOUSE2D  = 3'd6,
    KIND_MOUSE4D2 = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    TOOL_NONE   = 2'd0,
    TOOL_STYLUS = 2'd1,
    TOOL_CURSOR = 2'd2,
    TOOL_ERASER = 2'd3
  } tool_t;

  // last field in the lowest bits
  typedef struct packed {
    logic               second_channel;
    logic signed [10:0] aux_value;
    logic [7:0]         button_bits;
    logic signed [6:0]  tilt_y;
    logic signed [6:0]  tilt_x;
    logic [9:0]         pressure;
    logic [15:0]        y_position;
    logic [15:0]        x_position;
    logic               position_valid;
    logic               in_proximity;
    tool_t              tool_type;
    kind_t              packet_kind;
  } report_t;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } fb_stat_t;

endpackage

// ----- rtl/tp5_frame_buf.sv -----
module tp5_frame_buf #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_ready,
  input  logic            adv,
  output tp5_pkg::fb_stat_t stat,
  output tp5_pkg::frame_t frame
);
  import tp5_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH + 1);

  logic          s1_valid;
  oct_t          s1_byte;
  oct_t          fb [FRAME_LENGTH-1];
  logic [IW-1:0] byte_index;
  logic [IW-1:0] byte_index_next;
  logic [IW-1:0] idx0;
  logic [IW-1:0] idx1;
  logic [IW-1:0] idx_inc;
  oct_t          b0_eff;
  logic          frame_end;
  logic          cr_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready) begin
      s1_byte <= in_byte;
    end
  end

  always_comb begin
    idx0      = s1_byte[7] ? '0 : byte_index;
    idx1      = (idx0 >= IW'(BUFFER_DEPTH)) ? '0 : idx0;
    idx_inc   = idx1 + 1'b1;
    b0_eff    = (idx1 == '0) ? s1_byte : fb[0];
    frame_end = (idx_inc == IW'(FRAME_LENGTH)) && b0_eff[7];
    cr_clear  = (s1_byte == 8'h0d) && !b0_eff[7];
    byte_index_next = (frame_end || cr_clear) ? '0 : idx_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      fb[0]      <= '0;
    end else if (adv) begin
      byte_index <= byte_index_next;
      for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
        if (idx1 == IW'(i)) begin
          fb[i] <= s1_byte;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      frame[i] = fb[i];
    end
    frame[FRAME_LENGTH-1] = s1_byte;
    stat.valid     = s1_valid;
    stat.frame_end = frame_end;
  end

endmodule

// ----- rtl/tp5_decode.sv -----
module tp5_decode (
  input  logic             clk,
  input  logic             rst,
  input  tp5_pkg::frame_t  frame,
  input  tp5_pkg::fb_stat_t stat,
  input  logic             adv,
  output tp5_pkg::report_t report,
  output logic             known
);
  import tp5_pkg::*;

  localparam logic [10:0] ID_CURSOR_4D = 11'h094;
  localparam logic [10:0] ID_CURSOR_LENS = 11'h096;
  localparam logic [10:0] ID_CURSOR_2D = 11'h007;
  localparam logic [10:0] ROT_SPLIT = 11'd900;

  function automatic tool_t classify(input logic [11:0] id);
    logic [10:0] low;
    low = id[10:0];
    if (low == 11'h012 || low == 11'h022 || low == 11'h032 || low == 11'h042 ||
        low == 11'h052 || low == 11'h112) begin
      return TOOL_STYLUS;
    end
    if (low == ID_CURSOR_2D || low == ID_CURSOR_4D || low == ID_CURSOR_LENS) begin
      return TOOL_CURSOR;
    end
    return TOOL_ERASER;
  endfunction

  logic [11:0]        tool_id;
  tool_t              tool;
  logic [11:0]        new_id;
  tool_t              new_tool;
  logic               is_id;
  oct_t               b0;
  logic [9:0]         ten;
  logic [10:0]        rot;
  logic signed [11:0] aux_w;
  logic signed [11:0] aux_sat;
  logic               pos;

  always_comb begin
    b0       = frame[0];
    ten      = {frame[5][2:0], frame[6][6:0]};
    rot      = {frame[6][3:0], frame[7][6:0]};
    new_id   = {frame[1][6:0], frame[2][6:2]};
    new_tool = classify(new_id);
    is_id    = 1'b0;
    known    = 1'b1;
    pos      = 1'b0;
    aux_w    = '0;
    report   = '0;
    report.in_proximity = b0[6];
    report.packet_kind  = KIND_MOUSE4D;
    priority if ((b0 & 8'hfc) == 8'hc0) begin
      is_id = 1'b1;
      report.packet_kind  = KIND_TOOL_ID;
      report.in_proximity = 1'b1;
    end else if ((b0 & 8'hfe) == 8'h80) begin
      report.packet_kind  = KIND_OUT_PROX;
      report.in_proximity = 1'b0;
    end else if ((b0 & 8'hb8) == 8'ha0 || (b0 & 8'hbe) == 8'hb4) begin
      pos = 1'b1;
      if ((b0 & 8'hb8) == 8'ha0) begin
        report.packet_kind = KIND_PEN;
        report.pressure    = ten;
        report.button_bits = {5'b0, b0[2:1], 1'b0};
      end else begin
        report.packet_kind = KIND_AIRBRUSH;
        aux_w = $signed({2'b0, ten});
      end
      report.tilt_x = frame[7][6:0];
      report.tilt_y = frame[8][6:0];
    end else if ((b0 & 8'hbe) == 8'ha8 || (b0 & 8'hbe) == 8'hb0) begin
      pos = 1'b1;
      priority if (tool_id[10:0] == ID_CURSOR_4D) begin
        aux_w = frame[8][3] ? -$signed({2'b0, ten}) : $signed({2'b0, ten});
      end else if (tool_id[10:0] == ID_CURSOR_LENS) begin
        report.packet_kind = KIND_LENS;
        report.button_bits = frame[8];
      end else if (tool_id[10:0] == ID_CURSOR_2D) begin
        report.packet_kind = KIND_MOUSE2D;
        report.button_bits = {5'b0, frame[8][4:2]};
        aux_w = $signed({11'b0, frame[8][1]}) - $signed({11'b0, frame[8][0]});
      end else begin
        aux_w = '0;
      end
    end else if ((b0 & 8'hbe) == 8'haa) begin
      pos = 1'b1;
      report.packet_kind = KIND_MOUSE4D2;
      aux_w = (rot < ROT_SPLIT) ? -$signed({1'b0, rot})
                                : 12'sd1799 - $signed({1'b0, rot});
    end else begin
      known = 1'b0;
    end

    priority if (aux_w > 12'sd1023) begin
      aux_sat = 12'sd1023;
    end else if (aux_w < -12'sd1023) begin
      aux_sat = -12'sd1023;
    end else begin
      aux_sat = aux_w;
    end

    report.aux_value      = aux_sat[10:0];
    report.position_valid = pos;
    if (pos) begin
      report.x_position = {frame[1][6:0], frame[2][6:0], frame[3][6:5]};
      report.y_position = {frame[3][4:0], frame[4][6:0], frame[5][6:3]};
    end
    report.tool_type      = is_id ? new_tool : tool;
    report.second_channel = b0[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tool_id <= '0;
      tool    <= TOOL_NONE;
    end else if (adv && stat.frame_end && is_id) begin
      tool_id <= new_id;
      tool    <= new_tool;
    end
  end

endmodule

// ----- rtl/tablet_protocol5_stream_decoder.sv -----
// Pen tablet serial decoder.
// Slave channel: one received serial byte per word on s_tdata. A byte with
// bit 7 set starts a nine-byte binary frame; a carriage return outside a
// frame just resets the byte index.
// Master channel: one report word per decoded frame on m_tdata. Frames of
// unknown type and all non-final bytes give no word.
// Path: the last byte of a frame lands in the input register, then
// decodes into the output register, which presents the report; a stalled
// output holds the byte in the input register until the report is taken.
// Throughput: one byte per cycle unless the output stalls; the decode is a
// single combinational pass between the input and output registers.
// Stall: while m_tready is low and a report is held, the input register
// holds its byte and s_tready drops once it is full; bytes that give no
// report still wait behind it so order is kept.
// Reset: clears the byte index, the stored tool ID and tool class (no tool),
// and both valid flags. BUFFER_DEPTH sets where the byte index wraps.
module tablet_protocol5_stream_decoder #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] packet_kind, [4:3] tool_type, [5] in_proximity, [6] position_valid,
  // [22:7] x_position, [38:23] y_position, [48:39] pressure, [55:49] tilt_x,
  // [62:56] tilt_y, [70:63] button_bits, [81:71] aux_value,
  // [82] second_channel, [87:83] zero
  output logic [87:0] m_tdata
);
  import tp5_pkg::*;

  `include "tablet_protocol5_stream_decoder_assert.svh"

  fb_stat_t stat;
  frame_t   frame;
  report_t  rep;
  report_t  out_rep;
  logic     known;
  logic     adv;
  logic     load;

  assign adv      = stat.valid && (!m_tvalid || m_tready);
  assign s_tready = !stat.valid || adv;
  assign load     = adv && stat.frame_end && known;

  tp5_frame_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .adv      (adv),
    .stat     (stat),
    .frame    (frame)
  );

  tp5_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame),
    .stat   (stat),
    .adv    (adv),
    .report (rep),
    .known  (known)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      out_rep <= rep;
    end
  end

  assign m_tdata = {5'b0, out_rep};

  `TP5_ASSERT_NXT(a_accept_fills_stage, s_tvalid && s_tready, stat.valid)
  `TP5_ASSERT_NXT(a_frame_gives_report, load, m_tvalid)
  `TP5_ASSERT_NXT(a_taken_clears, m_tvalid && m_tready && !load, !m_tvalid)
  `TP5_ASSERT_IMP(a_id_has_tool, m_tvalid && out_rep.packet_kind == KIND_TOOL_ID,
    out_rep.tool_type != TOOL_NONE && out_rep.in_proximity)

endmodule

// ----- dv/tablet_protocol5_stream_decoder_tb.sv -----
`timescale 1ns / 100ps

module tablet_protocol5_stream_decoder_tb;
  import tp5_pkg::*;

  localparam int BUFFER_DEPTH = 32;
  localparam int STALL_LIMIT = 4000;
  localparam oct_t CR_BYTE = 8'h0d;
  localparam logic [10:0] ID_MOUSE4D = 11'h094;
  localparam logic [10:0] ID_LENS = 11'h096;
  localparam logic [10:0] ID_MOUSE2D = 11'h007;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  tablet_protocol5_stream_decoder #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // decoder state mirror
  oct_t        frame_mem [BUFFER_DEPTH] = '{default: '0};
  int unsigned wr_idx = 0;
  logic [11:0] tool_id = '0;
  tool_t       tool = TOOL_NONE;

  report_t     pending_reports [$];
  int unsigned src_idle = 0;
  int unsigned sink_idle = 0;
  int unsigned sent_bytes = 0;
  int unsigned checked = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned kind_seen [8] = '{default: 0};

  logic [10:0] known_ids [9] = '{11'h012, 11'h022, 11'h032, 11'h042, 11'h052, 11'h112,
                                 ID_MOUSE2D, ID_MOUSE4D, ID_LENS};

  function automatic tool_t tool_class(logic [11:0] id);
    case (id[10:0])
      11'h012, 11'h022, 11'h032, 11'h042, 11'h052, 11'h112: return TOOL_STYLUS;
      ID_MOUSE2D, ID_MOUSE4D, ID_LENS: return TOOL_CURSOR;
      default: return TOOL_ERASER;
    endcase
  endfunction

  function automatic bit decode_report(output report_t r);
    oct_t        d0;
    logic [9:0]  ten;
    logic [10:0] rot;
    int          aux;
    bit          pos;
    r = '0;
    pos = 1'b0;
    aux = 0;
    d0 = frame_mem[0];
    ten = {frame_mem[5][2:0], frame_mem[6][6:0]};
    r.in_proximity = d0[6];
    if ((d0 & 8'hfc) == 8'hc0) begin
      r.packet_kind = KIND_TOOL_ID;
      r.in_proximity = 1'b1;
      tool_id = {frame_mem[1][6:0], frame_mem[2][6:2]};
      tool = tool_class(tool_id);
    end else if ((d0 & 8'hfe) == 8'h80) begin
      r.packet_kind = KIND_OUT_PROX;
      r.in_proximity = 1'b0;
    end else if ((d0 & 8'hb8) == 8'ha0 || (d0 & 8'hbe) == 8'hb4) begin
      pos = 1'b1;
      if ((d0 & 8'hb8) == 8'ha0) begin
        r.packet_kind = KIND_PEN;
        r.pressure = ten;
        r.button_bits = d0 & 8'h06;
      end else begin
        r.packet_kind = KIND_AIRBRUSH;
        aux = ten;
      end
      r.tilt_x = frame_mem[7][6:0];
      r.tilt_y = frame_mem[8][6:0];
    end else if ((d0 & 8'hbe) == 8'ha8 || (d0 & 8'hbe) == 8'hb0) begin
      pos = 1'b1;
      r.packet_kind = KIND_MOUSE4D;
      case (tool_id[10:0])
        ID_MOUSE4D: begin
          aux = ten;
          if (frame_mem[8][3]) aux = -aux;
        end
        ID_LENS: begin
          r.packet_kind = KIND_LENS;
          r.button_bits = frame_mem[8];
        end
        ID_MOUSE2D: begin
          r.packet_kind = KIND_MOUSE2D;
          r.button_bits = {5'd0, frame_mem[8][4:2]};
          aux = int'(frame_mem[8][1]) - int'(frame_mem[8][0]);
        end
        default: ;
      endcase
    end else if ((d0 & 8'hbe) == 8'haa) begin
      rot = {frame_mem[6][3:0], frame_mem[7][6:0]};
      pos = 1'b1;
      r.packet_kind = KIND_MOUSE4D2;
      aux = (rot < 900) ? -int'(rot) : 1799 - int'(rot);
    end else begin
      return 1'b0;
    end
    r.tool_type = tool;
    r.position_valid = pos;
    if (pos) begin
      r.x_position = {frame_mem[1][6:0], frame_mem[2][6:0], frame_mem[3][6:5]};
      r.y_position = {frame_mem[3][4:0], frame_mem[4][6:0], frame_mem[5][6:3]};
    end
    if (aux > 1023) aux = 1023;
    if (aux < -1023) aux = -1023;
    r.aux_value = aux[10:0];
    r.second_channel = d0[0];
    return 1'b1;
  endfunction

  function automatic bit absorb_byte(oct_t b, output report_t r);
    bit got;
    got = 1'b0;
    r = '0;
    if (b[7]) wr_idx = 0;
    if (wr_idx >= BUFFER_DEPTH) wr_idx = 0;
    frame_mem[wr_idx] = b;
    wr_idx++;
    if (wr_idx == FRAME_LENGTH && frame_mem[0][7]) begin
      got = decode_report(r);
      wr_idx = 0;
    end else if (b == CR_BYTE && !frame_mem[0][7]) begin
      wr_idx = 0;
    end
    return got;
  endfunction

  task automatic send_byte(input oct_t b);
    report_t r;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    if (absorb_byte(b, r)) pending_reports.push_back(r);
  endtask

  task automatic send_frame(input frame_t f, input int n = FRAME_LENGTH);
    for (int i = 0; i < n; i++) send_byte(f[i]);
  endtask

  function automatic frame_t fill_frame(oct_t hdr, oct_t fill);
    frame_t f;
    for (int i = 1; i < FRAME_LENGTH; i++) f[i] = fill;
    f[0] = hdr;
    return f;
  endfunction

  function automatic frame_t rand_frame(oct_t hdr);
    frame_t f;
    int     pick;
    pick = $urandom_range(7);
    for (int i = 1; i < FRAME_LENGTH; i++) begin
      f[i] = (pick == 0) ? 8'h7f : (pick == 1) ? 8'h00 : oct_t'($urandom_range(127));
    end
    f[0] = hdr;
    return f;
  endfunction

  function automatic frame_t id_frame(oct_t hdr, logic [11:0] id);
    frame_t f;
    f = rand_frame(hdr);
    f[1] = {1'b0, id[11:5]};
    f[2] = {1'b0, id[4:0], f[2][1:0]};
    return f;
  endfunction

  function automatic frame_t rot_frame(oct_t hdr, logic [10:0] rot);
    frame_t f;
    f = rand_frame(hdr);
    f[6] = {1'b0, f[6][6:4], rot[10:7]};
    f[7] = {1'b0, rot[6:0]};
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH report %0d %s: got 0x%0h want 0x%0h", checked, what, got, want);
    errors++;
  endtask

  task automatic compare_report(input logic [87:0] word, input report_t want);
    report_t got;
    got = report_t'(word[82:0]);
    if (word[87:83] !== 5'd0) flag_mismatch("padding", word[87:83], 0);
    if (got.packet_kind !== want.packet_kind)
      flag_mismatch("packet_kind", got.packet_kind, want.packet_kind);
    if (got.tool_type !== want.tool_type)
      flag_mismatch("tool_type", got.tool_type, want.tool_type);
    if (got.in_proximity !== want.in_proximity)
      flag_mismatch("in_proximity", got.in_proximity, want.in_proximity);
    if (got.position_valid !== want.position_valid)
      flag_mismatch("position_valid", got.position_valid, want.position_valid);
    if (got.x_position !== want.x_position)
      flag_mismatch("x_position", got.x_position, want.x_position);
    if (got.y_position !== want.y_position)
      flag_mismatch("y_position", got.y_position, want.y_position);
    if (got.pressure !== want.pressure)
      flag_mismatch("pressure", got.pressure, want.pressure);
    if (got.tilt_x !== want.tilt_x) flag_mismatch("tilt_x", got.tilt_x, want.tilt_x);
    if (got.tilt_y !== want.tilt_y) flag_mismatch("tilt_y", got.tilt_y, want.tilt_y);
    if (got.button_bits !== want.button_bits)
      flag_mismatch("button_bits", got.button_bits, want.button_bits);
    if (got.aux_value !== want.aux_value)
      flag_mismatch("aux_value", got.aux_value, want.aux_value);
    if (got.second_channel !== want.second_channel)
      flag_mismatch("second_channel", got.second_channel, want.second_channel);
  endtask

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("report with none pending", m_tdata[31:0], 0);
        end else begin
          compare_report(m_tdata, pending_reports[0]);
          kind_seen[pending_reports[0].packet_kind]++;
          void'(pending_reports.pop_front());
        end
        checked++;
      end
    end
  end

  task automatic test_tool_ids();
    send_frame(id_frame(8'hc1, 12'h812));
    send_frame(id_frame(8'hc3, 12'hfff));
    send_frame(id_frame(8'hc0, 12'h000));
  endtask

  task automatic test_pen_and_airbrush();
    frame_t f;
    send_frame(id_frame(8'hc2, 12'h022));
    send_frame(fill_frame(8'he7, 8'h7f));
    send_frame(fill_frame(8'ha0, 8'h00));
    f = fill_frame(8'ha2, 8'h15);
    f[7] = 8'h40;
    f[8] = 8'h3f;
    send_frame(f);
    send_frame(fill_frame(8'hf5, 8'h7f));
    send_frame(fill_frame(8'h81, 8'h7f));
  endtask

  task automatic test_cursor_frames();
    frame_t f;
    send_frame(id_frame(8'hc0, {1'b0, ID_MOUSE4D}));
    send_frame(fill_frame(8'he9, 8'h7f));
    send_frame(fill_frame(8'hb0, 8'h00));
    send_frame(id_frame(8'hc0, {1'b0, ID_LENS}));
    send_frame(fill_frame(8'ha8, 8'h7f));
    send_frame(id_frame(8'hc1, {1'b1, ID_MOUSE2D}));
    f = fill_frame(8'hf1, 8'h2a);
    f[8] = 8'h01;
    send_frame(f);
    f[8] = 8'h1e;
    send_frame(f);
    // cursor frame while an eraser ID is held
    send_frame(id_frame(8'hc0, 12'h123));
    send_frame(fill_frame(8'hb1, 8'h33));
  endtask

  task automatic test_rotation();
    send_frame(rot_frame(8'haa, 11'd0));
    send_frame(rot_frame(8'heb, 11'd899));
    send_frame(rot_frame(8'hab, 11'd900));
    send_frame(rot_frame(8'hea, 11'd2047));
  endtask

  task automatic test_unknown_and_cr();
    send_frame(fill_frame(8'h98, 8'h11));
    send_byte(8'h41);
    send_byte(CR_BYTE);
    // carriage returns inside a frame are plain data
    send_frame(fill_frame(8'ha0, CR_BYTE));
  endtask

  task automatic test_buffer_wrap();
    for (int i = 0; i < 2 * BUFFER_DEPTH + 5; i++) send_byte(8'h55);
    send_frame(fill_frame(8'ha4, 8'h66));
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned cnt;
    logic [11:0] id;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        id = $urandom_range(3) == 0 ? 12'($urandom) :
             {1'($urandom), known_ids[$urandom_range(8)]};
        send_frame(id_frame(8'hc0 | oct_t'($urandom_range(3)), id));
      end else if (sel < 20) begin
        send_frame(rand_frame(8'h80 | oct_t'($urandom_range(1))));
      end else if (sel < 38) begin
        send_frame(rand_frame(8'ha0 | oct_t'($urandom & 8'h47)));
      end else if (sel < 48) begin
        send_frame(rand_frame(8'hb4 | oct_t'($urandom & 8'h41)));
      end else if (sel < 68) begin
        send_frame(rand_frame(($urandom_range(1) ? 8'ha8 : 8'hb0) | oct_t'($urandom & 8'h41)));
      end else if (sel < 78) begin
        send_frame(rand_frame(8'haa | oct_t'($urandom & 8'h41)));
      end else if (sel < 84) begin
        send_frame(rand_frame(8'h80 | oct_t'($urandom_range(127))));
      end else if (sel < 89) begin
        send_frame(rand_frame(8'h80 | oct_t'($urandom_range(127))), $urandom_range(1, 8));
      end else if (sel < 94) begin
        cnt = $urandom_range(1, 12);
        repeat (cnt) send_byte(oct_t'($urandom_range(255)));
      end else if (sel < 98) begin
        cnt = $urandom_range(6);
        repeat (cnt) send_byte(oct_t'($urandom_range(127)));
        send_byte(CR_BYTE);
      end else begin
        cnt = $urandom_range(BUFFER_DEPTH + 1, 2 * BUFFER_DEPTH + 6);
        repeat (cnt) send_byte(oct_t'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    src_idle = 16;
    sink_idle = 74;
    test_tool_ids();
    test_pen_and_airbrush();
    test_cursor_frames();
    test_rotation();
    test_unknown_and_cr();
    test_buffer_wrap();
    test_random_traffic(520);
    src_idle = 74;
    sink_idle = 16;
    test_random_traffic(520);
    src_idle = 0;
    sink_idle = 0;
    test_random_traffic(520);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0)
      flag_mismatch("reports never delivered", 0, pending_reports.size());
    $display("Sent %0d bytes, checked %0d reports under three stall profiles.",
             sent_bytes, checked);
    $display("Reports by kind id/oop/pen/air/4d/lens/2d/4d2: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
